### rtl/core/hidx_pkg.sv
// hidx_pkg: shared codes, field widths and default sizes for the hash index table
// no dependencies
package hidx_pkg;

    // field widths of one transaction
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned KEY_W    = 31;
    localparam int unsigned OFS_W    = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned LIVE_W   = 10;

    // key * 31 needs five more bits than the key
    localparam int unsigned PROD_W = KEY_W + 5;

    // default table geometry
    localparam int unsigned DEF_NUM_BUCKETS = 128;
    localparam int unsigned DEF_WAYS        = 4;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_REMOVED  = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    // one slot of a bucket row
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [OFS_W-1:0] offset;
    } t_slot;

endpackage

### rtl/core/hash_index_table.sv
// hash_index_table: key-to-offset index table with bounded buckets
// depends on hidx_pkg (codes, widths, slot type)
//
// usage:
//   input channel: i_valid / o_stall with i_cmd, i_key, i_value_offset. a
//   transaction is taken at a clock edge with i_valid high and o_stall low.
//   output channel: o_valid / i_stall with o_status, o_found_offset and
//   o_live_entries, one result transaction for every command.
//   the bucket is (key * 31) mod NUM_BUCKETS, found in the fold, quotient and
//   remainder states: the key is folded into a short sum of byte-times-residue
//   terms, a reciprocal multiply estimates the quotient, then one multiply,
//   subtract and conditional subtract leave the remainder. the read state then
//   reads the bucket row from the synchronous row memory, and the exec state
//   matches all ways, writes the row back and loads the output register.
//   one command at a time: o_stall is high until the result is loaded, and a
//   new transaction is taken in the cycle after the previous result was loaded.
//   reset: a clearing pass writes every bucket row empty, one row per cycle;
//   o_stall stays high during it. the live count resets to zero.
//   stall: the result waits in the output register; the block takes the next
//   command meanwhile and holds its write-back until the register is free.
module hash_index_table #(
    parameter int unsigned NUM_BUCKETS = hidx_pkg::DEF_NUM_BUCKETS,
    parameter int unsigned WAYS        = hidx_pkg::DEF_WAYS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [hidx_pkg::CMD_W-1:0]     i_cmd,
    input  logic [hidx_pkg::KEY_W-1:0]     i_key,
    input  logic [hidx_pkg::OFS_W-1:0]     i_value_offset,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [hidx_pkg::STATUS_W-1:0]  o_status,
    output logic [hidx_pkg::OFS_W-1:0]     o_found_offset,
    output logic [hidx_pkg::LIVE_W-1:0]    o_live_entries
);

    import hidx_pkg::*;

    // geometry derived from the parameters
    localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned CNT_W  = $clog2(NUM_BUCKETS * WAYS + 1);

    // four byte chunks times residues below 4096 stay under 2^22
    localparam int unsigned SUM_W  = 22;

    // (31 * 2^(8*i)) mod NUM_BUCKETS for each byte of the key
    localparam logic [BKT_W-1:0] FOLD_C0 = BKT_W'((64'd31 << 0) % NUM_BUCKETS);
    localparam logic [BKT_W-1:0] FOLD_C1 = BKT_W'((64'd31 << 8) % NUM_BUCKETS);
    localparam logic [BKT_W-1:0] FOLD_C2 = BKT_W'((64'd31 << 16) % NUM_BUCKETS);
    localparam logic [BKT_W-1:0] FOLD_C3 = BKT_W'((64'd31 << 24) % NUM_BUCKETS);

    // reciprocal of the bucket count, scaled by 2^SUM_W
    localparam logic [SUM_W:0]   BAR_M   = (SUM_W + 1)'((64'd1 << SUM_W) / NUM_BUCKETS);
    localparam logic [SUM_W-1:0] NB_SUM  = SUM_W'(NUM_BUCKETS);

    localparam logic [BKT_W-1:0] LAST_ROW = BKT_W'(NUM_BUCKETS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FOLD,
        S_QUOT,
        S_REM,
        S_READ,
        S_EXEC
    } t_state;

    typedef t_slot [WAYS-1:0] t_row;

    // bucket row memory
    t_row mem [NUM_BUCKETS];

    // sequencer and command registers
    t_state            r_state, n_state;
    logic [BKT_W-1:0]  r_clr_addr, n_clr_addr;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SUM_W-1:0]  r_quot, n_quot;
    logic [BKT_W-1:0]  r_rem, n_rem;
    t_cmd              r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [OFS_W-1:0]  r_ofs, n_ofs;
    logic [CNT_W-1:0]  r_count, n_count;

    // output register
    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [OFS_W-1:0]  r_found, n_found;
    logic [LIVE_W-1:0] r_live, n_live;

    // memory ports
    t_row              r_row;
    logic              mem_we;
    logic [BKT_W-1:0]  mem_waddr;
    t_row              mem_wdata;

    // bucket arithmetic
    logic [2*SUM_W-1:0] quot_prod;
    logic [SUM_W-1:0]   rem_diff;

    // bucket match
    logic              any_hit, any_free;
    logic [WAY_W-1:0]  hit_idx, free_idx;
    t_row              upd_row;
    logic              out_free;
    logic [CNT_W+LIVE_W-1:0] live_ext;

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_found_offset = r_found;
    assign o_live_entries = r_live;

    // quotient estimate is low by at most one, so one subtract fixes the remainder
    assign quot_prod = (2*SUM_W)'(r_sum) * (2*SUM_W)'(BAR_M);
    assign rem_diff  = r_sum - SUM_W'(r_quot * NB_SUM);

    // lowest matching way and lowest free way of the registered row
    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_row[w].valid && (r_row[w].key == r_key)) begin
                any_hit = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!r_row[w].valid) begin
                any_free = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
    end

    // the output register can take a result this cycle
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_sum       = r_sum;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_ofs       = r_ofs;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_found     = r_found;
        n_live      = r_live;
        mem_we      = 1'b0;
        mem_waddr   = r_rem;
        mem_wdata   = r_row;
        upd_row     = r_row;
        live_ext    = '0;

        unique case (r_state)
            S_CLEAR: begin
                // write one empty row per cycle
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_key   = i_key;
                    n_ofs   = i_value_offset;
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                // same residue as key * 31, but small enough for the reciprocal
                n_sum   = SUM_W'(r_key[7:0])       * SUM_W'(FOLD_C0)
                        + SUM_W'(r_key[15:8])      * SUM_W'(FOLD_C1)
                        + SUM_W'(r_key[23:16])     * SUM_W'(FOLD_C2)
                        + SUM_W'(r_key[KEY_W-1:24]) * SUM_W'(FOLD_C3);
                n_state = S_QUOT;
            end
            S_QUOT: begin
                n_quot  = SUM_W'(quot_prod >> SUM_W);
                n_state = S_REM;
            end
            S_REM: begin
                if (rem_diff >= NB_SUM) begin
                    n_rem = BKT_W'(rem_diff - NB_SUM);
                end else begin
                    n_rem = BKT_W'(rem_diff);
                end
                n_state = S_READ;
            end
            S_READ: begin
                // row read at r_rem lands in r_row
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_status = ST_NOTFOUND;
                    n_found  = '0;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (any_hit) begin
                                upd_row[hit_idx].offset = r_ofs;
                                mem_we   = 1'b1;
                                n_status = ST_UPDATED;
                            end else if (any_free) begin
                                upd_row[free_idx].valid  = 1'b1;
                                upd_row[free_idx].key    = r_key;
                                upd_row[free_idx].offset = r_ofs;
                                mem_we   = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_status = ST_INSERTED;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (any_hit) begin
                                n_status = ST_FOUND;
                                n_found  = r_row[hit_idx].offset;
                            end
                        end
                        CMD_REMOVE: begin
                            if (any_hit) begin
                                upd_row[hit_idx].valid = 1'b0;
                                mem_we   = 1'b1;
                                n_status = ST_REMOVED;
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        default: begin
                            // unused command leaves the table alone
                        end
                    endcase
                    mem_wdata   = upd_row;
                    live_ext    = {{LIVE_W{1'b0}}, n_count};
                    n_live      = live_ext[LIVE_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // row memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_row <= mem[r_rem];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_sum    <= n_sum;
        r_quot   <= n_quot;
        r_rem    <= n_rem;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_ofs    <= n_ofs;
        r_status <= n_status;
        r_found  <= n_found;
        r_live   <= n_live;
    end

endmodule
